>>> rtl/utf8_stream_decoder_assert.svh
// Assertion macros shared by the decoder modules.
// Both expect clk and rst_n in scope.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication.
`define UTF8SD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8sd: same-cycle check failed");

// Next-cycle implication.
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8sd: next-cycle check failed");

`endif

>>> rtl/utf8sd_pkg.sv
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 3;   // 0..4 results per byte

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // One decoded byte's worth of output: every result but the last is U+FFFD.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CP_W-1:0]  last_cp;
    logic             str_end;
  } utf8sd_job_t;

endpackage

`default_nettype wire

>>> rtl/utf8sd_ifs.sv
`default_nettype none

interface utf8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_end;

  modport source (output valid, output data_byte, output string_end, input ready);
  modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface utf8sd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        run_last;
  logic        string_done;

  modport source (output valid, output code_point, output run_last,
                  output string_done, input ready);
  modport sink   (input valid, input code_point, input run_last,
                  input string_done, output ready);
endinterface

`default_nettype wire

>>> rtl/utf8sd_decode.sv
`default_nettype none
`include "utf8_stream_decoder_assert.svh"

module utf8sd_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  utf8sd_in_if.sink          in_bus,
  output utf8sd_pkg::utf8sd_job_t job,
  output logic               job_valid,
  input  wire logic          job_ready
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_end_r;

  logic        seq_active_r,   seq_active_nxt;
  logic [1:0]  seq_needed_r,   seq_needed_nxt;
  logic [1:0]  seq_gathered_r, seq_gathered_nxt;
  logic [20:0] payload_r,      payload_nxt;

  logic        advance;

  // start-byte decode (no sequence pending)
  logic [1:0]  st_need;
  logic [20:0] st_bits;
  logic        st_emit;
  logic [20:0] st_cp;

  logic        is_cont;
  logic [1:0]  gath_inc;
  logic [20:0] pay_shift;
  logic [2:0]  flush_cnt;
  utf8sd_pkg::utf8sd_job_t job_c;

  always_comb begin
    st_need = 2'd0;
    st_bits = '0;
    if (in_byte_r[7:5] == 3'b110) begin
      st_need = 2'd1;
      st_bits = {16'd0, in_byte_r[4:0]};
    end else if (in_byte_r[7:4] == 4'b1110) begin
      st_need = 2'd2;
      st_bits = {17'd0, in_byte_r[3:0]};
    end else if (in_byte_r[7:3] == 5'b11110) begin
      st_need = 2'd3;
      st_bits = {18'd0, in_byte_r[2:0]};
    end
    // ASCII, bad lead, or a lead on the final byte all give one result
    st_emit = !in_byte_r[7] || (st_need == 2'd0) || in_end_r;
    st_cp   = !in_byte_r[7] ? {13'd0, in_byte_r} : utf8sd_pkg::REPL_CP;
  end

  always_comb begin
    is_cont   = in_byte_r[7:6] == 2'b10;
    gath_inc  = seq_gathered_r + 2'd1;
    pay_shift = {payload_r[14:0], in_byte_r[5:0]};
    flush_cnt = {1'b0, seq_gathered_r} + 3'd1;

    job_c.str_end    = in_end_r;
    job_c.count      = '0;
    job_c.last_cp    = utf8sd_pkg::REPL_CP;
    seq_active_nxt   = seq_active_r;
    seq_needed_nxt   = seq_needed_r;
    seq_gathered_nxt = seq_gathered_r;
    payload_nxt      = payload_r;

    if (seq_active_r && is_cont) begin
      if (gath_inc >= seq_needed_r) begin
        job_c.count    = 3'd1;
        job_c.last_cp  = pay_shift;
        seq_active_nxt = 1'b0;
      end else if (in_end_r) begin
        // unfinished at string end: lead plus gathered bytes
        job_c.count    = {1'b0, gath_inc} + 3'd1;
        seq_active_nxt = 1'b0;
      end else begin
        seq_gathered_nxt = gath_inc;
        payload_nxt      = pay_shift;
      end
    end else begin
      // broken sequence flushes first, then this byte decodes afresh
      job_c.count = seq_active_r ? flush_cnt : 3'd0;
      if (st_emit) begin
        job_c.count   = job_c.count + 3'd1;
        job_c.last_cp = st_cp;
      end
      seq_active_nxt   = !st_emit;
      seq_needed_nxt   = st_need;
      seq_gathered_nxt = 2'd0;
      payload_nxt      = st_bits;
    end

    if (in_end_r || !seq_active_nxt) begin
      seq_active_nxt   = 1'b0;
      seq_needed_nxt   = 2'd0;
      seq_gathered_nxt = 2'd0;
      payload_nxt      = '0;
    end
  end

  assign job       = job_c;
  assign job_valid = in_valid_r && (job_c.count != 3'd0);
  assign advance   = in_valid_r && ((job_c.count == 3'd0) || job_ready);
  assign in_bus.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r <= in_bus.data_byte;
      in_end_r  <= in_bus.string_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_active_r   <= 1'b0;
      seq_needed_r   <= 2'd0;
      seq_gathered_r <= 2'd0;
      payload_r      <= '0;
    end else if (advance) begin
      seq_active_r   <= seq_active_nxt;
      seq_needed_r   <= seq_needed_nxt;
      seq_gathered_r <= seq_gathered_nxt;
      payload_r      <= payload_nxt;
    end
  end

  // a pending sequence is always short of its continuation bytes
  `UTF8SD_ASSERT_NOW(a_seq_short, seq_active_r,
                     seq_needed_r != 2'd0 && seq_gathered_r < seq_needed_r)

endmodule

`default_nettype wire

>>> rtl/utf8sd_emit.sv
`default_nettype none
`include "utf8_stream_decoder_assert.svh"

module utf8sd_emit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire utf8sd_pkg::utf8sd_job_t job,
  input  wire logic          job_valid,
  output logic               job_ready,
  utf8sd_out_if.source       out_bus
);

  logic        em_valid_r;
  logic [2:0]  em_rem_r;
  logic [20:0] em_cp_r;
  logic        em_end_r;
  logic        on_last;
  logic        xfer;

  assign on_last   = em_rem_r == 3'd1;
  assign xfer      = em_valid_r && out_bus.ready;
  assign job_ready = !em_valid_r || (xfer && on_last);

  assign out_bus.valid       = em_valid_r;
  assign out_bus.code_point  = on_last ? em_cp_r : utf8sd_pkg::REPL_CP;
  assign out_bus.run_last    = on_last;
  assign out_bus.string_done = on_last && em_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      em_rem_r   <= 3'd0;
    end else if (job_ready) begin
      em_valid_r <= job_valid;
      if (job_valid) begin
        em_rem_r <= job.count;
      end
    end else if (xfer) begin
      em_rem_r <= em_rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      em_cp_r  <= job.last_cp;
      em_end_r <= job.str_end;
    end
  end

  `UTF8SD_ASSERT_NOW(a_rem_range, em_valid_r, em_rem_r != 3'd0 && em_rem_r <= 3'd4)
  `UTF8SD_ASSERT_NEXT(a_stall_hold, em_valid_r && !out_bus.ready,
                      em_valid_r && $stable(em_rem_r))
  `UTF8SD_ASSERT_NEXT(a_burst_step, xfer && !on_last,
                      em_valid_r && em_rem_r == $past(em_rem_r) - 3'd1)

endmodule

`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder.
// in_bus carries one byte per transfer (data_byte) with string_end set on
// the string's final byte. out_bus carries one code point per transfer;
// run_last marks the last result of an input byte, string_done the final
// result of a string. Malformed input produces U+FFFD.
// Both channels use valid/ready; a transfer happens when both are high.
// Results are sent from a result register fed by the input register.
// Throughput is one byte per cycle; lead and middle bytes of a multi-byte
// sequence produce nothing and take no output slot. A byte that yields k
// results (k up to 4, only on error flushes) holds the result register
// until all k are out; meanwhile bytes that yield nothing keep flowing and
// the first byte that yields a result waits in the input register.
// A stall on out_bus holds the current result; in_bus.ready drops as soon
// as a byte that yields a result waits in the input register.
// Synchronous reset (rst_n low) drops any pending sequence and any
// undelivered results; no clearing pass follows.
`default_nettype none

module utf8_stream_decoder (
  input  wire logic    clk,
  input  wire logic    rst_n,
  utf8sd_in_if.sink    in_bus,
  utf8sd_out_if.source out_bus
);

  utf8sd_pkg::utf8sd_job_t job;
  logic                    job_valid;
  logic                    job_ready;

  utf8sd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  utf8sd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CP_W = utf8sd_pkg::CP_W;
  localparam logic [CP_W-1:0] REPL_CP = utf8sd_pkg::REPL_CP;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned TARGET_BYTES   = 425;
  localparam int unsigned LONG_HOLD      = 60;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            run_last;
    logic            string_done;
  } cp_result_t;

  // Bit-level model of the decoder plus the queue of code points still owed.
  class cp_scoreboard;
    bit              seq_open;
    bit [1:0]        cont_needed;
    bit [1:0]        cont_seen;
    logic [CP_W-1:0] payload;
    cp_result_t      owed_cps[$];
    cp_result_t      byte_cps[$];
    int unsigned     mismatches;
    int unsigned     checked;

    function void drop_seq();
      seq_open    = 1'b0;
      cont_needed = '0;
      cont_seen   = '0;
      payload     = '0;
    endfunction

    function void add_cp(logic [CP_W-1:0] cp);
      cp_result_t r;
      if (byte_cps.size() < 4) begin
        r.code_point  = cp;
        r.run_last    = 1'b0;
        r.string_done = 1'b0;
        byte_cps.push_back(r);
      end
    endfunction

    // one replacement for the lead, one per continuation already taken
    function void flush_seq();
      add_cp(REPL_CP);
      for (int k = 0; k < cont_seen; k++) add_cp(REPL_CP);
      drop_seq();
    endfunction

    function void decode_lead(logic [7:0] b, bit last);
      bit [1:0]        need;
      logic [CP_W-1:0] bits;
      if (b[7] == 1'b0) begin
        add_cp(CP_W'(b));
        return;
      end
      casez (b)
        8'b110?????: begin need = 2'd1; bits = CP_W'(b[4:0]); end
        8'b1110????: begin need = 2'd2; bits = CP_W'(b[3:0]); end
        8'b11110???: begin need = 2'd3; bits = CP_W'(b[2:0]); end
        default: begin
          add_cp(REPL_CP);
          return;
        end
      endcase
      if (last) begin
        add_cp(REPL_CP);
        return;
      end
      seq_open    = 1'b1;
      cont_needed = need;
      cont_seen   = '0;
      payload     = bits;
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      byte_cps.delete();
      if (seq_open) begin
        if (b[7:6] == 2'b10) begin
          payload   = {payload[CP_W-7:0], b[5:0]};
          cont_seen = cont_seen + 2'd1;
          if (cont_seen >= cont_needed) begin
            add_cp(payload);
            drop_seq();
          end else if (last) begin
            flush_seq();
          end
        end else begin
          flush_seq();
          decode_lead(b, last);
        end
      end else begin
        decode_lead(b, last);
      end
      if (last) drop_seq();
      if (byte_cps.size() > 0) begin
        byte_cps[byte_cps.size()-1].run_last    = 1'b1;
        byte_cps[byte_cps.size()-1].string_done = last;
      end
      foreach (byte_cps[i]) owed_cps.push_back(byte_cps[i]);
    endfunction

    function void check_cp(cp_result_t got);
      cp_result_t want;
      checked++;
      if (owed_cps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d unexpected: cp %h run_last %b string_done %b",
                   checked, got.code_point, got.run_last, got.string_done);
        return;
      end
      want = owed_cps.pop_front();
      if (got.code_point !== want.code_point || got.run_last !== want.run_last ||
          got.string_done !== want.string_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected cp %h rl %b sd %b, got cp %h rl %b sd %b",
                   checked, want.code_point, want.run_last, want.string_done,
                   got.code_point, got.run_last, got.string_done);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  utf8sd_in_if  in_bus();
  utf8sd_out_if out_bus();

  utf8_stream_decoder u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  cp_scoreboard sb = new();

  bit          src_gaps  = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned sent_bytes = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  str_bytes[$];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog: cycles without a transfer on either channel
  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.string_end <= last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_byte(b, last);
    sent_bytes++;
  endtask

  task automatic send_string(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // sender holds off until every owed code point has come out
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.owed_cps.size() != 0);
  endtask

  function automatic void push_utf8(logic [20:0] cp, int unsigned len);
    case (len)
      1: str_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] random_cp(int unsigned len);
    case (len)
      1:       return 21'($urandom_range(0, 'h7F));
      2:       return 21'($urandom_range(0, 'h7FF));
      3:       return 21'($urandom_range(0, 'hFFFF));
      default: return 21'($urandom_range(0, 'h1FFFFF));
    endcase
  endfunction

  function automatic void build_string(int unsigned n_cps);
    int unsigned len;
    int unsigned roll;
    int unsigned cut;
    str_bytes.delete();
    for (int i = 0; i < n_cps; i++) begin
      roll = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (roll < 82) begin
        push_utf8(random_cp(len), len);
      end else if (roll < 91) begin
        str_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        // truncated sequence: a following non-continuation byte breaks it
        len = $urandom_range(2, 4);
        push_utf8(random_cp(len), len);
        cut = $urandom_range(1, len - 1);
        repeat (cut) void'(str_bytes.pop_back());
      end
    end
  endfunction

  initial begin : result_sink
    int unsigned stall;
    cp_result_t  got;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (long_hold) begin
        stall     = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        stall = sink_gaps ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got.code_point  = out_bus.code_point;
      got.run_last    = out_bus.run_last;
      got.string_done = out_bus.string_done;
      sb.check_cp(got);
    end
  end

  initial begin : byte_source
    int unsigned str_idx;
    int unsigned n_cps;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.data_byte  <= '0;
    in_bus.string_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ASCII extremes, two- and three-byte forms
    send_string('{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC});
    // largest four-byte value
    send_string('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
    // lone continuations and invalid leads
    send_string('{8'h80, 8'hBF, 8'hF8, 8'hFF});
    // sequence broken by ASCII, which decodes on its own
    send_string('{8'hE2, 8'h82, 8'h41});
    // four replacements from one byte
    send_string('{8'hF0, 8'h80, 8'h80, 8'hF8});
    // unfinished at string end, then a lead as the whole string
    send_string('{8'hF0, 8'h90, 8'h80});
    send_string('{8'hC3});
    drain_results();

    str_idx = 0;
    while (sent_bytes < TARGET_BYTES) begin
      str_idx++;
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      n_cps     = $urandom_range(1, 8);
      if (str_idx == 8) begin
        // receiver stalls while the sender streams back-to-back
        long_hold = 1'b1;
        src_gaps  = 1'b0;
        n_cps     = 20;
      end
      if (str_idx == 30) drain_results();
      build_string(n_cps);
      send_string(str_bytes);
    end
    in_bus.valid <= 1'b0;

    while (sb.owed_cps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_cps.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> utf8_stream_decoder.f
+incdir+rtl
rtl/utf8sd_pkg.sv
rtl/utf8sd_ifs.sv
rtl/utf8sd_decode.sv
rtl/utf8sd_emit.sv
rtl/utf8_stream_decoder.sv
tb/tb.sv
